@@ hw/rtl/ial_pkg.sv @@
// Shared constants, command codes, sequencer states and result type for the list engine.
`timescale 1ns / 1ps
`default_nettype none

package ial_pkg;

  // Store geometry
  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int POS_W  = 5;
  localparam int CMD_W  = 4;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_READ         = 4'd0,
    CMD_SEARCH       = 4'd1,
    CMD_INSERT_AT    = 4'd2,
    CMD_INSERT_FRONT = 4'd3,
    CMD_INSERT_BACK  = 4'd4,
    CMD_REMOVE_AT    = 4'd5,
    CMD_REMOVE_FRONT = 4'd6,
    CMD_REMOVE_BACK  = 4'd7,
    CMD_REPLACE      = 4'd8
  } cmd_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD_WAIT,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_UP_RD,
    ST_UP_WR,
    ST_DN_RD,
    ST_DN_WR,
    ST_DONE
  } state_t;

  // One result item
  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]  found_index;
    logic [CNT_W-1:0]  count_after;
  } res_t;

endpackage

`default_nettype wire

@@ hw/rtl/ial_core.sv @@
// Sequencer, two-port list store and shared compare/step unit of the list engine.
`timescale 1ns / 1ps
`default_nettype none

module ial_core (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [ial_pkg::CMD_W-1:0]  cmd_in,
  input  wire logic [ial_pkg::POS_W-1:0]  pos_in,
  input  wire logic [ial_pkg::DATA_W-1:0] val_in,
  input  wire logic [ial_pkg::CNT_W-1:0]  cap,
  input  wire logic                      out_free,
  output      logic                      idle,
  output      logic                      done,
  output      ial_pkg::res_t             res
);
  import ial_pkg::*;

  // List store: one write port, one registered read port
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Sequencer registers
  state_t            state, state_next;
  logic [CMD_W-1:0]  op, op_next;
  logic [POS_W-1:0]  pos, pos_next;
  logic [DATA_W-1:0] val, val_next;
  logic [CNT_W-1:0]  idx, idx_next;
  logic [CNT_W-1:0]  count, count_next;
  logic              r_ok, r_ok_next;
  logic [DATA_W-1:0] r_rd, r_rd_next;
  logic [CNT_W-1:0]  r_found, r_found_next;

  // Shared step unit: neighbor indexes and the bound compare
  logic [CNT_W-1:0] idx_inc;
  logic [CNT_W-1:0] idx_dec;
  logic [CNT_W-1:0] cnt_dec;
  logic             pos_lt_cnt;

  assign idx_inc    = idx + CNT_W'(1);
  assign idx_dec    = idx - CNT_W'(1);
  assign cnt_dec    = count - CNT_W'(1);
  assign pos_lt_cnt = (POS_W'(count) > pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    op      <= op_next;
    pos     <= pos_next;
    val     <= val_next;
    idx     <= idx_next;
    r_ok    <= r_ok_next;
    r_rd    <= r_rd_next;
    r_found <= r_found_next;
  end

  // Next state and store control
  always_comb begin
    state_next   = state;
    op_next      = op;
    pos_next     = pos;
    val_next     = val;
    idx_next     = idx;
    count_next   = count;
    r_ok_next    = r_ok;
    r_rd_next    = r_rd;
    r_found_next = r_found;
    rd_addr      = idx[ADDR_W-1:0];
    wr_en        = 1'b0;
    wr_addr      = idx[ADDR_W-1:0];
    wr_data      = rd_data;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          op_next    = cmd_in;
          pos_next   = pos_in;
          val_next   = val_in;
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        r_ok_next    = 1'b0;
        r_rd_next    = '0;
        r_found_next = '0;
        state_next   = ST_DONE;
        case (op) inside
          CMD_READ: begin
            if (count != '0) begin
              rd_addr    = pos_lt_cnt ? pos[ADDR_W-1:0] : cnt_dec[ADDR_W-1:0];
              r_ok_next  = pos_lt_cnt;
              state_next = ST_RD_WAIT;
            end
          end
          CMD_SEARCH: begin
            r_found_next = count;
            idx_next     = '0;
            if (count != '0) begin
              state_next = ST_SRCH_RD;
            end
          end
          CMD_INSERT_AT, CMD_INSERT_FRONT, CMD_INSERT_BACK: begin
            // insertion point goes into pos for the shift loop
            if (op == CMD_INSERT_FRONT) begin
              pos_next = '0;
            end else if (op == CMD_INSERT_BACK) begin
              pos_next = POS_W'(count);
            end
            idx_next = count;
            if (count < cap && !((op == CMD_INSERT_AT) && (pos > POS_W'(count)))) begin
              state_next = ST_UP_RD;
            end
          end
          CMD_REMOVE_AT, CMD_REMOVE_FRONT, CMD_REMOVE_BACK: begin
            if (op == CMD_REMOVE_FRONT) begin
              idx_next = '0;
            end else if (op == CMD_REMOVE_BACK) begin
              idx_next = cnt_dec;
            end else begin
              idx_next = CNT_W'(pos);
            end
            if (count != '0 && (op != CMD_REMOVE_AT || pos_lt_cnt)) begin
              state_next = ST_DN_RD;
            end
          end
          CMD_REPLACE: begin
            if (pos_lt_cnt) begin
              wr_en     = 1'b1;
              wr_addr   = pos[ADDR_W-1:0];
              wr_data   = val;
              r_ok_next = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end

      ST_RD_WAIT: begin
        r_rd_next  = rd_data;
        state_next = ST_DONE;
      end

      // Search: read one entry, then compare it
      ST_SRCH_RD: begin
        rd_addr    = idx[ADDR_W-1:0];
        state_next = ST_SRCH_CMP;
      end

      ST_SRCH_CMP: begin
        if (rd_data == val) begin
          r_found_next = idx;
          r_ok_next    = 1'b1;
          state_next   = ST_DONE;
        end else if (idx_inc >= count) begin
          state_next = ST_DONE;
        end else begin
          idx_next   = idx_inc;
          state_next = ST_SRCH_RD;
        end
      end

      // Insert: move entries up from the tail, then drop the value in
      ST_UP_RD: begin
        if (POS_W'(idx) > pos) begin
          rd_addr    = idx_dec[ADDR_W-1:0];
          state_next = ST_UP_WR;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = pos[ADDR_W-1:0];
          wr_data    = val;
          count_next = count + CNT_W'(1);
          r_ok_next  = 1'b1;
          state_next = ST_DONE;
        end
      end

      ST_UP_WR: begin
        wr_en      = 1'b1;
        wr_addr    = idx[ADDR_W-1:0];
        idx_next   = idx_dec;
        state_next = ST_UP_RD;
      end

      // Remove: move entries down toward the hole
      ST_DN_RD: begin
        if (idx_inc < count) begin
          rd_addr    = idx_inc[ADDR_W-1:0];
          state_next = ST_DN_WR;
        end else begin
          count_next = cnt_dec;
          r_ok_next  = 1'b1;
          state_next = ST_DONE;
        end
      end

      ST_DN_WR: begin
        wr_en      = 1'b1;
        wr_addr    = idx[ADDR_W-1:0];
        idx_next   = idx_inc;
        state_next = ST_DN_RD;
      end

      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign idle            = (state == ST_IDLE);
  assign done            = (state == ST_DONE);
  assign res.ok          = r_ok;
  assign res.read_value  = r_rd;
  assign res.found_index = r_found;
  assign res.count_after = count;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_CNT)
    else $error("list count above depth");

  a_count_only_at_done: assert property (@(posedge clk) disable iff (rst)
    ($past(!rst) && count != $past(count)) |-> (state == ST_DONE))
    else $error("count changed outside command completion");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (done && !out_free) |=> done)
    else $error("result dropped while output slot busy");

  a_start_exec: assert property (@(posedge clk) disable iff (rst)
    (idle && start) |=> (state == ST_EXEC))
    else $error("accepted command not executed");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (wr_en && (state == ST_UP_WR || state == ST_DN_WR)) |-> (idx < DEPTH_CNT))
    else $error("shift write outside store");

endmodule

`default_nettype wire

@@ hw/rtl/indexed_array_list_engine_top.sv @@
// Top level of the indexed list engine: handshakes, capacity register and result register.
// Sequencing: replace and failed commands finish in the execute state; read adds a wait state
//   for the registered store read; search reads then compares each entry in turn; insert and
//   remove read then write each shifted entry. One command at a time; a full-list search is the
//   worst case; input is ready again when the result loads into the output register.
// Reset: count cleared, capacity register set to 16, output empty; store contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module indexed_array_list_engine_top (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output      logic                      in_ready,
  input  wire logic [ial_pkg::CMD_W-1:0]  cmd,
  input  wire logic [ial_pkg::POS_W-1:0]  position,
  input  wire logic [ial_pkg::DATA_W-1:0] value,
  output      logic                      out_valid,
  input  wire logic                      out_ready,
  output      logic                      ok,
  output      logic [ial_pkg::DATA_W-1:0] read_value,
  output      logic [ial_pkg::CNT_W-1:0]  found_index,
  output      logic [ial_pkg::CNT_W-1:0]  count_after,
  input  wire logic                      cfg_wen,
  input  wire logic [4:0]                cfg_wdata
);
  import ial_pkg::*;

  // Capacity register and its clamp to 1..DEPTH
  logic [4:0]       capacity_limit;
  logic [CNT_W-1:0] cap_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= 5'd16;
    end else if (cfg_wen) begin
      capacity_limit <= cfg_wdata;
    end
  end

  always_comb begin
    if (capacity_limit == '0) begin
      cap_eff = CNT_W'(1);
    end else if (CNT_W'(capacity_limit) > DEPTH_CNT) begin
      cap_eff = DEPTH_CNT;
    end else begin
      cap_eff = CNT_W'(capacity_limit);
    end
  end

  // Core
  logic core_idle;
  logic core_done;
  logic out_free;
  res_t core_res;
  res_t out_res;

  assign in_ready = core_idle;
  assign out_free = !out_valid || out_ready;

  ial_core u_core (
    .clk      (clk),
    .rst      (rst),
    .start    (in_valid && in_ready),
    .cmd_in   (cmd),
    .pos_in   (position),
    .val_in   (value),
    .cap      (cap_eff),
    .out_free (out_free),
    .idle     (core_idle),
    .done     (core_done),
    .res      (core_res)
  );

  // Output register: loads a finished result when the slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (core_done && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_done && out_free) begin
      out_res <= core_res;
    end
  end

  assign ok          = out_res.ok;
  assign read_value  = out_res.read_value;
  assign found_index = out_res.found_index;
  assign count_after = out_res.count_after;

endmodule

`default_nettype wire

@@ sim/indexed_array_list_engine_top_test.sv @@
// Self-checking testbench for the indexed list engine: random and directed commands, shadow list.
`timescale 1ns / 1ps

module indexed_array_list_engine_top_test;
  import ial_pkg::*;

  localparam int LAT_SLACK = 2 * DEPTH + 8;  // worst shift or search plus margin
  localparam int LONG_HOLD = 120;            // receiver hold-off that backs up the input
  localparam int PHASE_LEN = 85;

  // Shadow copy of the list; predicts one result per command and checks results in order
  class list_shadow;
    logic [DATA_W-1:0] cells [DEPTH];
    int                fill;
    int                capacity_reg;
    res_t              pending_results [$];
    int                mismatches;

    function new();
      fill         = 0;
      capacity_reg = 16;
      mismatches   = 0;
    endfunction

    // Capacity as the block applies it: 0 acts as 1, above DEPTH acts as DEPTH
    function int room();
      if (capacity_reg == 0) return 1;
      if (capacity_reg > DEPTH) return DEPTH;
      return capacity_reg;
    endfunction

    function bit shift_in(int at, logic [DATA_W-1:0] val);
      if (fill >= room() || at > fill) return 1'b0;
      for (int i = fill; i > at; i--) cells[i] = cells[i - 1];
      cells[at] = val;
      fill++;
      return 1'b1;
    endfunction

    function bit shift_out(int at);
      if (fill == 0 || at >= fill) return 1'b0;
      for (int i = at; i + 1 < fill; i++) cells[i] = cells[i + 1];
      fill--;
      return 1'b1;
    endfunction

    // Apply one accepted command to the shadow list and queue its result
    function void apply_command(logic [CMD_W-1:0] code, logic [POS_W-1:0] pos,
                                logic [DATA_W-1:0] val);
      res_t want;
      want = '0;
      case (code)
        CMD_READ: begin
          if (pos < fill) begin
            want.ok         = 1'b1;
            want.read_value = cells[pos];
          end else if (fill > 0) begin
            want.read_value = cells[fill - 1];
          end
        end
        CMD_SEARCH: begin
          // walk down so the lowest match wins
          want.found_index = CNT_W'(fill);
          for (int i = fill - 1; i >= 0; i--) begin
            if (cells[i] == val) begin
              want.found_index = CNT_W'(i);
              want.ok          = 1'b1;
            end
          end
        end
        CMD_INSERT_AT:    want.ok = shift_in(int'(pos), val);
        CMD_INSERT_FRONT: want.ok = shift_in(0, val);
        CMD_INSERT_BACK:  want.ok = shift_in(fill, val);
        CMD_REMOVE_AT:    want.ok = shift_out(int'(pos));
        CMD_REMOVE_FRONT: want.ok = shift_out(0);
        CMD_REMOVE_BACK:  want.ok = (fill > 0) ? shift_out(fill - 1) : 1'b0;
        CMD_REPLACE: begin
          if (pos < fill) begin
            cells[pos] = val;
            want.ok    = 1'b1;
          end
        end
        default: ;  // unknown codes change nothing
      endcase
      want.count_after = CNT_W'(fill);
      pending_results.push_back(want);
    endfunction

    task report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      mismatches++;
      $display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $time);
    endtask

    task compare_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result with none pending", DATA_W'(1), DATA_W'(0));
        return;
      end
      want = pending_results.pop_front();
      if (got.ok !== want.ok) report_mismatch("ok", DATA_W'(got.ok), DATA_W'(want.ok));
      if (got.read_value !== want.read_value)
        report_mismatch("read_value", got.read_value, want.read_value);
      if (got.found_index !== want.found_index)
        report_mismatch("found_index", DATA_W'(got.found_index), DATA_W'(want.found_index));
      if (got.count_after !== want.count_after)
        report_mismatch("count_after", DATA_W'(got.count_after), DATA_W'(want.count_after));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [CMD_W-1:0]  cmd;
  logic [POS_W-1:0]  position;
  logic [DATA_W-1:0] value;
  logic              out_valid;
  logic              out_ready;
  logic              ok;
  logic [DATA_W-1:0] read_value;
  logic [CNT_W-1:0]  found_index;
  logic [CNT_W-1:0]  count_after;
  logic              cfg_wen;
  logic [4:0]        cfg_wdata;

  list_shadow shadow = new();

  bit source_gaps = 1'b1;
  bit sink_stalls = 1'b1;
  int holds_requested = 0;
  int holds_granted = 0;

  indexed_array_list_engine_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .position    (position),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .ok          (ok),
    .read_value  (read_value),
    .found_index (found_index),
    .count_after (count_after),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Check every result transfer
  always @(posedge clk) begin : result_monitor
    res_t seen;
    if (out_valid === 1'b1 && out_ready === 1'b1) begin
      seen = {ok, read_value, found_index, count_after};
      shadow.compare_result(seen);
    end
  end

  // Receiver: random ready bursts, plus a long hold-off on request
  initial begin : result_sink
    int  burst_left;
    bit  burst_ready;
    burst_left  = 0;
    burst_ready = 1'b1;
    out_ready   = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_granted != holds_requested) begin
        holds_granted++;
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (!sink_stalls) begin
        out_ready <= 1'b1;
      end else begin
        if (burst_left == 0) begin
          burst_ready = $urandom_range(0, 1);
          burst_left  = $urandom_range(1, 16);
        end
        out_ready <= burst_ready;
        burst_left--;
      end
    end
  end

  // Present one command and hold it until the transfer
  task automatic offer_command(logic [CMD_W-1:0] code, logic [POS_W-1:0] pos,
                               logic [DATA_W-1:0] val);
    @(negedge clk);
    in_valid <= 1'b1;
    cmd      <= code;
    position <= pos;
    value    <= val;
    do @(posedge clk); while (in_ready !== 1'b1);
    shadow.apply_command(code, pos, val);
  endtask

  // Occasional idle burst on the command side
  task automatic source_gap();
    int n;
    if (!source_gaps || $urandom_range(0, 3) != 0) return;
    n = $urandom_range(1, 16);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Drain all results, then write the capacity register
  task automatic set_capacity(logic [4:0] cap);
    @(negedge clk);
    in_valid <= 1'b0;
    while (shadow.pending_results.size() != 0) @(posedge clk);
    repeat (LAT_SLACK) @(posedge clk);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_wen <= 1'b0;
    shadow.capacity_reg = int'(cap);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return DATA_W'($urandom_range(0, 3));  // small pool gives duplicates
    if (r < 3) return '1;
    return $urandom;
  endfunction

  // Random commands; growth and shrink bias alternate so the count sweeps its range
  task automatic random_commands(int n);
    int                r;
    bit                filling;
    bit                grow;
    logic [CMD_W-1:0]  code;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    for (int k = 0; k < n; k++) begin
      filling = ((k / 24) % 2) == 0;
      r = $urandom_range(0, 99);
      if (r < 4) begin
        code = CMD_W'($urandom_range(int'(CMD_REPLACE) + 1, 15));
      end else if (r < 14) begin
        code = CMD_READ;
      end else if (r < 26) begin
        code = CMD_SEARCH;
      end else if (r < 34) begin
        code = CMD_REPLACE;
      end else begin
        grow = (r < 80) ? filling : !filling;
        case ($urandom_range(0, 2))
          0:       code = grow ? CMD_INSERT_AT    : CMD_REMOVE_AT;
          1:       code = grow ? CMD_INSERT_FRONT : CMD_REMOVE_FRONT;
          default: code = grow ? CMD_INSERT_BACK  : CMD_REMOVE_BACK;
        endcase
      end
      if ($urandom_range(0, 4) != 0) pos = POS_W'($urandom_range(0, shadow.fill));
      else pos = POS_W'($urandom_range(0, 31));
      if (code == CMD_SEARCH && shadow.fill > 0 && $urandom_range(0, 2) != 0)
        val = shadow.cells[$urandom_range(0, shadow.fill - 1)];
      else
        val = pick_value();
      offer_command(code, pos, val);
      source_gap();
    end
  endtask

  // Main sequence
  initial begin : stimulus
    logic [4:0] caps [8];
    caps = '{5'd0, 5'd1, 5'd31, 5'd17, 5'd4, 5'd2, 5'd9, 5'd16};
    rst       = 1'b1;
    in_valid  = 1'b0;
    cmd       = '0;
    position  = '0;
    value     = '0;
    cfg_wen   = 1'b0;
    cfg_wdata = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty list failures, edge values, every command
    offer_command(CMD_READ,         5'd0,  32'h0000_0000);
    offer_command(CMD_REMOVE_FRONT, 5'd0,  32'h0000_0000);
    offer_command(CMD_REMOVE_BACK,  5'd0,  32'h0000_0000);
    offer_command(CMD_REMOVE_AT,    5'd0,  32'h0000_0000);
    offer_command(CMD_SEARCH,       5'd0,  32'h0000_0000);
    offer_command(CMD_REPLACE,      5'd0,  32'h1234_5678);
    offer_command(CMD_INSERT_AT,    5'd1,  32'hDEAD_BEEF);
    offer_command(CMD_INSERT_BACK,  5'd31, 32'hFFFF_FFFF);
    source_gap();
    offer_command(CMD_INSERT_FRONT, 5'd0,  32'h0000_0000);
    offer_command(CMD_INSERT_AT,    5'd1,  32'hA5A5_A5A5);
    offer_command(CMD_INSERT_AT,    5'd3,  32'h5A5A_5A5A);
    offer_command(CMD_READ,         5'd2,  32'h0000_0000);
    offer_command(CMD_READ,         5'd31, 32'h0000_0000);
    offer_command(CMD_SEARCH,       5'd0,  32'hFFFF_FFFF);
    source_gap();
    offer_command(CMD_SEARCH,       5'd0,  32'h1234_5678);
    offer_command(CMD_REPLACE,      5'd0,  32'h8000_0001);
    offer_command(CMD_REPLACE,      5'd4,  32'h7FFF_FFFE);
    offer_command(CMD_INSERT_AT,    5'd16, 32'h0F0F_0F0F);
    offer_command(CMD_REMOVE_AT,    5'd1,  32'h0000_0000);
    offer_command(CMD_REMOVE_AT,    5'd31, 32'h0000_0000);
    offer_command(CMD_REMOVE_BACK,  5'd0,  32'h0000_0000);
    offer_command(CMD_REMOVE_FRONT, 5'd0,  32'h0000_0000);
    offer_command(4'd9,             5'd3,  32'hFFFF_FFFF);
    offer_command(4'd15,            5'd31, 32'hFFFF_FFFF);

    // Capacity phases
    for (int p = 0; p < 8; p++) begin
      set_capacity(caps[p]);
      if (p == 2) begin
        // receiver holds off while the sender keeps offering; list also fills up
        holds_requested++;
        repeat (20) offer_command(CMD_INSERT_BACK, 5'd0, $urandom);
      end
      if (p == 7) begin
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
      end
      random_commands(PHASE_LEN);
    end
    random_commands(PHASE_LEN);

    // Drain and finish
    @(negedge clk);
    in_valid <= 1'b0;
    while (shadow.pending_results.size() != 0) @(posedge clk);
    repeat (LAT_SLACK) @(posedge clk);
    if (shadow.mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Hang guard
  initial begin : watchdog
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
